// ----- rtl/hga_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hga_pkg: shared types and constants of the gradient histogram accumulator
// Item and result layouts, command codes, store geometry, stage structs.
// ---------------------------------------------------------------------------
package hga_pkg;

	localparam int NUM_BINS      = 1024;
	localparam int NUM_FEATURES  = 256;
	localparam int BIN_FIELD_W   = 10;
	localparam int FEAT_FIELD_W  = 8;
	localparam int VALUE_W       = 32;
	localparam int SUM_W         = 64;
	localparam int BIN_AW        = $clog2(NUM_BINS);
	localparam int FEAT_AW       = $clog2(NUM_FEATURES);
	localparam int GBIN_W        = BIN_FIELD_W + 1;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_ACC   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_RDCLR = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_CLEAR = 1'b0,
		ST_RUN   = 1'b1
	} store_state_t;

	typedef struct packed {
		cmd_t                        command;
		logic [BIN_FIELD_W-1:0]      bin_index;
		logic [FEAT_FIELD_W-1:0]     feature_index;
		logic signed [VALUE_W-1:0]   grad_value;
		logic signed [VALUE_W-1:0]   hess_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0]     grad_sum;
		logic signed [SUM_W-1:0]     hess_sum;
		logic                        error_flag;
	} out_item_t;

	// Bin lookup stage handed to the sum store
	typedef struct packed {
		logic                        valid;
		cmd_t                        cmd;
		logic [BIN_AW-1:0]           addr;
		logic                        bad;
		logic [VALUE_W-1:0]          grad;
		logic [VALUE_W-1:0]          hess;
	} map_t;

endpackage

// ----- rtl/hga_bin_map.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hga_bin_map: offset table and global bin computation
// Holds the per-feature offset memory and forms the global bin of stage 1.
// ---------------------------------------------------------------------------
module hga_bin_map import hga_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	input  logic     dense_mode,
	output map_t     map
);

	logic [BIN_FIELD_W-1:0] off_mem [NUM_FEATURES];
	logic [BIN_FIELD_W-1:0] off_s1;
	logic [FEAT_AW-1:0]     faddr;
	logic                   feat_ok;
	logic                   v_s1;
	in_item_t               item_s1;
	logic                   feat_ok_s1;
	logic                   use_off;
	logic [GBIN_W-1:0]      gbin;

	assign faddr   = FEAT_AW'(item.feature_index);
	assign feat_ok = 32'(item.feature_index) < 32'(NUM_FEATURES);

	// Load commands write at their accept edge; the next item reads after it
	always_ff @(posedge clk) begin
		if (accept && item.command == CMD_LOAD && feat_ok) begin
			off_mem[faddr] <= item.bin_index;
		end
		off_s1 <= off_mem[faddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= item;
			feat_ok_s1 <= feat_ok;
		end
	end

	always_comb begin
		use_off = dense_mode && item_s1.command == CMD_ACC;
		if (use_off) begin
			gbin = GBIN_W'(item_s1.bin_index) + GBIN_W'(off_s1);
		end else begin
			gbin = GBIN_W'(item_s1.bin_index);
		end
		map.valid = v_s1 && item_s1.command != CMD_LOAD;
		map.cmd   = item_s1.command;
		map.addr  = BIN_AW'(gbin);
		map.bad   = (use_off && !feat_ok_s1) || (32'(gbin) >= 32'(NUM_BINS));
		map.grad  = item_s1.grad_value;
		map.hess  = item_s1.hess_value;
	end

endmodule

// ----- rtl/hga_bin_store.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hga_bin_store: gradient and hessian sum memories
// Clearing pass after reset, read-modify-write with forwarding, sticky flag.
// ---------------------------------------------------------------------------
module hga_bin_store import hga_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  map_t      map,
	output logic      busy,
	output logic      pend_s2,
	output logic      res_valid,
	output out_item_t res
);

	logic [SUM_W-1:0]   grad_mem [NUM_BINS];
	logic [SUM_W-1:0]   hess_mem [NUM_BINS];
	logic [SUM_W-1:0]   grad_rd_s2;
	logic [SUM_W-1:0]   hess_rd_s2;

	store_state_t       st_q;
	store_state_t       st_d;
	logic [BIN_AW-1:0]  clr_cnt_q;
	logic [BIN_AW-1:0]  clr_cnt_d;

	logic               v_s2;
	cmd_t               cmd_s2;
	logic [BIN_AW-1:0]  addr_s2;
	logic               bad_s2;
	logic [VALUE_W-1:0] grad_s2;
	logic [VALUE_W-1:0] hess_s2;

	logic               fw_v_q;
	logic [BIN_AW-1:0]  fw_addr_q;
	logic [SUM_W-1:0]   fw_grad_q;
	logic [SUM_W-1:0]   fw_hess_q;

	logic               sticky_q;
	logic               sticky_d;

	logic [SUM_W-1:0]   old_g;
	logic [SUM_W-1:0]   old_h;
	logic [SUM_W:0]     add_g;
	logic [SUM_W:0]     add_h;
	logic [SUM_W-1:0]   new_g;
	logic [SUM_W-1:0]   new_h;
	logic               we_run;
	logic               err_now;
	logic               we;
	logic [BIN_AW-1:0]  wa;
	logic [SUM_W-1:0]   wg;
	logic [SUM_W-1:0]   wh;

	// Returns {saturated, clamped sum}
	function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		logic [SUM_W-1:0] bx;
		logic [SUM_W-1:0] r;
		logic [SUM_W:0]   o;
		bx = {{(SUM_W-VALUE_W){b[VALUE_W-1]}}, b};
		r  = a + bx;
		if (a[SUM_W-1] == bx[SUM_W-1] && r[SUM_W-1] != a[SUM_W-1]) begin
			o = {1'b1, a[SUM_W-1], {(SUM_W-1){~a[SUM_W-1]}}};
		end else begin
			o = {1'b0, r};
		end
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (we) begin
			grad_mem[wa] <= wg;
			hess_mem[wa] <= wh;
		end
		grad_rd_s2 <= grad_mem[map.addr];
		hess_rd_s2 <= hess_mem[map.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			clr_cnt_q <= '0;
			v_s2      <= 1'b0;
			fw_v_q    <= 1'b0;
			sticky_q  <= 1'b0;
		end else begin
			st_q      <= st_d;
			clr_cnt_q <= clr_cnt_d;
			v_s2      <= map.valid;
			fw_v_q    <= we_run;
			sticky_q  <= sticky_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2    <= map.cmd;
		addr_s2   <= map.addr;
		bad_s2    <= map.bad;
		grad_s2   <= map.grad;
		hess_s2   <= map.hess;
		fw_addr_q <= addr_s2;
		fw_grad_q <= new_g;
		fw_hess_q <= new_h;
	end

	// Stage 2: merge the last write, add, clamp, flag
	always_comb begin
		if (fw_v_q && fw_addr_q == addr_s2) begin
			old_g = fw_grad_q;
			old_h = fw_hess_q;
		end else begin
			old_g = grad_rd_s2;
			old_h = hess_rd_s2;
		end
		add_g = sat_add(old_g, grad_s2);
		add_h = sat_add(old_h, hess_s2);
		if (cmd_s2 == CMD_ACC) begin
			new_g = add_g[SUM_W-1:0];
			new_h = add_h[SUM_W-1:0];
		end else begin
			new_g = '0;
			new_h = '0;
		end
		we_run  = v_s2 && !bad_s2 && (cmd_s2 == CMD_ACC || cmd_s2 == CMD_RDCLR);
		err_now = sticky_q || (v_s2 && bad_s2)
			|| (v_s2 && !bad_s2 && cmd_s2 == CMD_ACC && (add_g[SUM_W] || add_h[SUM_W]));
		sticky_d = sticky_q;
		if (v_s2) begin
			sticky_d = (cmd_s2 == CMD_RDCLR) ? 1'b0 : err_now;
		end
		res_valid      = v_s2 && (cmd_s2 == CMD_READ || cmd_s2 == CMD_RDCLR);
		res.grad_sum   = bad_s2 ? '0 : old_g;
		res.hess_sum   = bad_s2 ? '0 : old_h;
		res.error_flag = err_now;
	end

	// Clearing sequencer and write port mux
	always_comb begin
		st_d      = st_q;
		clr_cnt_d = clr_cnt_q;
		we        = 1'b0;
		wa        = addr_s2;
		wg        = new_g;
		wh        = new_h;
		case (st_q)
			ST_CLEAR: begin
				we        = 1'b1;
				wa        = clr_cnt_q;
				wg        = '0;
				wh        = '0;
				clr_cnt_d = clr_cnt_q + 1'b1;
				if (clr_cnt_q == BIN_AW'(NUM_BINS - 1)) begin
					st_d = ST_RUN;
				end
			end
			ST_RUN: begin
				we = we_run;
			end
			default: begin
				st_d = ST_CLEAR;
			end
		endcase
	end

	assign busy    = st_q == ST_CLEAR;
	assign pend_s2 = v_s2;

endmodule

// ----- rtl/hga_out_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hga_out_fifo: result queue
// Small queue that decouples the store pipeline from a stalling receiver.
// ---------------------------------------------------------------------------
module hga_out_fifo import hga_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  out_item_t          push_data,
	input  logic               pop,
	output logic [FIFO_AW:0]   count,
	output logic               head_valid,
	output out_item_t          head
);

	out_item_t            fifo_mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	assign count      = cnt_q;
	assign head_valid = cnt_q != '0;
	assign head       = fifo_mem[rd_ptr_q];

endmodule

// ----- rtl/gradient_histogram_accumulator_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gradient_histogram_accumulator_top: per-bin gradient/hessian histogram
// Accumulates Q8.24 gradients and hessians into saturating Q40.24 bin sums.
// ---------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): one command per
//   transaction: load offset, accumulate, read bin, read and clear bin.
//   result channel (result_valid / result_stall / result): one transaction
//   per read or read-and-clear, in command order, carrying both sums and
//   the sticky error flag. Loads and accumulates return nothing.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes dense_mode;
//   always ready. Write it only while no command is in flight.
// Path: a read passes the stage 1 register, the stage 2 register and the
//   result queue before it shows on the result port.
// Throughput: one command per cycle while item_stall is low, including
//   back-to-back accumulates to the same bin; the store read is bridged by
//   forwarding the previous write. The four-entry result queue bounds how
//   far commands run ahead of a stalled receiver: item_stall rises once
//   queued plus in-flight results could fill it.
// Reset: the bin stores are swept to zero, one bin per cycle, over all 1024
//   bins after reset; item_stall stays high during that pass. The offset
//   table is not cleared and must be loaded before dense accumulates.
// ---------------------------------------------------------------------------
module gradient_histogram_accumulator_top import hga_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	logic               dense_mode_q;
	logic               accept;
	map_t               map;
	logic               busy;
	logic               pend_s2;
	logic               res_valid;
	out_item_t          res;
	logic [FIFO_AW:0]   fifo_cnt;
	logic [FIFO_AW+1:0] pend;
	logic               pop;

	// Configuration register: hold dense_mode between writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dense_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			dense_mode_q <= cfg_data;
		end
	end

	// Admission: block during the clearing pass and when results could
	// overflow the queue (queued + stage 1 + stage 2 + this one)
	always_comb begin
		pend = (FIFO_AW+2)'(fifo_cnt) + (FIFO_AW+2)'(map.valid) + (FIFO_AW+2)'(pend_s2);
		item_stall = busy || (pend >= (FIFO_AW+2)'(FIFO_DEPTH));
	end

	assign accept = item_valid && !item_stall;
	assign pop    = result_valid && !result_stall;

	// Stage 1: offset lookup and global bin
	hga_bin_map u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.dense_mode (dense_mode_q),
		.map        (map)
	);

	// Stage 2: sum read-modify-write and sticky flag
	hga_bin_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.map       (map),
		.busy      (busy),
		.pend_s2   (pend_s2),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result queue toward the receiver
	hga_out_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (res),
		.pop        (pop),
		.count      (fifo_cnt),
		.head_valid (result_valid),
		.head       (result)
	);

endmodule

// ----- rtl/hga_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hga_checker: port-level checks of the histogram accumulator
// Watches the top-level ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
module hga_checker import hga_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input in_item_t  item,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	// A stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	// Clearing pass holds off commands right after reset
	a_clear_stall: assert property (@(posedge clk)
		!$past(arst_n) |-> item_stall)
		else $error("command taken during clearing pass");

	// A result into an empty queue comes from an accepted read or read-and-clear
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall, 3)
			&& ($past(item.command, 3) == CMD_READ
			|| $past(item.command, 3) == CMD_RDCLR))
		else $error("result without a matching read");

endmodule

bind gradient_histogram_accumulator_top hga_checker u_hga_checker (.*);
